// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a condition implies a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// a condition implies a consequent in the same cycle
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/cmm_pkg.sv -----
// ----------------------------------------------------------------------
// cmm_pkg
// types and constants of the complex matrix multiplier
// ----------------------------------------------------------------------
`default_nettype none
package cmm_pkg;
   localparam int DIM_W = 4;
   localparam int IDX_W = 3;
   localparam int OUT_W = 36;

   typedef enum logic [1:0] {
      ACT_LOAD_A  = 2'd0,
      ACT_LOAD_B  = 2'd1,
      ACT_COMPUTE = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_ROWS  = 2'd0,
      REG_INNER = 2'd1,
      REG_COLS  = 2'd2,
      REG_NONE  = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // sizes of one compute run, already clamped
   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] inner;
      logic [DIM_W-1:0] cols;
   } dims_type;
endpackage
`default_nettype wire

// ----- rtl/cmm_ram.sv -----
// ----------------------------------------------------------------------
// cmm_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------
`default_nettype none
module cmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/cmm_front.sv -----
// ----------------------------------------------------------------------
// cmm_front
// accepts items, writes loads into the stores, queues compute commands
// ----------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module cmm_front #(
   parameter int MAX_DIM = 8,
   parameter int ELEM_WIDTH = 16,
   parameter int AW = 6
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire [1:0]                    req_action,
   input  wire [cmm_pkg::IDX_W-1:0]     req_row_index,
   input  wire [cmm_pkg::IDX_W-1:0]     req_col_index,
   input  wire signed [ELEM_WIDTH-1:0]  req_real_part,
   input  wire signed [ELEM_WIDTH-1:0]  req_imag_part,
   input  wire [cmm_pkg::DIM_W-1:0]     cfg_rows,
   input  wire [cmm_pkg::DIM_W-1:0]     cfg_inner,
   input  wire [cmm_pkg::DIM_W-1:0]     cfg_cols,
   output logic                         wr_a,
   output logic                         wr_b,
   output logic [AW-1:0]                wr_addr,
   output logic [2*ELEM_WIDTH-1:0]      wr_data,
   output logic                         cmd_valid,
   output cmm_pkg::dims_type            cmd_dims,
   input  wire                          cmd_take,
   input  wire                          back_busy
);
   localparam int RW = $clog2(MAX_DIM) > 0 ? $clog2(MAX_DIM) : 1;
   localparam logic [cmm_pkg::DIM_W-1:0] MAXD = cmm_pkg::DIM_W'(MAX_DIM);

   // one-deep command queue
   logic                 q_valid_ff, q_valid_in;
   cmm_pkg::dims_type    q_dims_ff, q_dims_in;
   logic                 accept;
   logic                 in_range;

   function automatic logic [cmm_pkg::DIM_W-1:0] clamp(input logic [cmm_pkg::DIM_W-1:0] d);
      logic [cmm_pkg::DIM_W-1:0] r;
      r = d;
      if (d == '0) r = cmm_pkg::DIM_W'(1);
      else if (d > MAXD) r = MAXD;
      return r;
   endfunction

   assign busy   = q_valid_ff || back_busy;
   assign accept = start && !busy;
   assign in_range = (32'(req_row_index) < MAX_DIM) && (32'(req_col_index) < MAX_DIM);

   // store writes
   always_comb begin
      wr_a    = accept && in_range && (req_action == cmm_pkg::ACT_LOAD_A);
      wr_b    = accept && in_range && (req_action == cmm_pkg::ACT_LOAD_B);
      wr_addr = AW'({req_row_index[RW-1:0], req_col_index[RW-1:0]});
      wr_data = {req_real_part, req_imag_part};
   end

   // queue next state
   always_comb begin
      q_valid_in = q_valid_ff;
      q_dims_in  = q_dims_ff;
      if (cmd_take) q_valid_in = 1'b0;
      if (accept && req_action == cmm_pkg::ACT_COMPUTE) begin
         q_valid_in      = 1'b1;
         q_dims_in.rows  = clamp(cfg_rows);
         q_dims_in.inner = clamp(cfg_inner);
         q_dims_in.cols  = clamp(cfg_cols);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= q_valid_in;
      end
      q_dims_ff <= q_dims_in;
   end

   assign cmd_valid = q_valid_ff;
   assign cmd_dims  = q_dims_ff;

   `ASSERT_NOW(a_take_valid, clock, reset, cmd_take, q_valid_ff)
   `ASSERT_NEXT(a_cmd_queued, clock, reset, accept && req_action == cmm_pkg::ACT_COMPUTE, q_valid_ff)
endmodule
`default_nettype wire

// ----- rtl/cmm_back.sv -----
// ----------------------------------------------------------------------
// cmm_back
// walks rows, columns and inner index, multiplies and accumulates
// ----------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module cmm_back #(
   parameter int MAX_DIM = 8,
   parameter int ELEM_WIDTH = 16,
   parameter int AW = 6
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             cmd_valid,
   input  wire cmm_pkg::dims_type          cmd_dims,
   output logic                            cmd_take,
   output logic                            back_busy,
   output logic [AW-1:0]                   rd_a_addr,
   output logic [AW-1:0]                   rd_b_addr,
   input  wire [2*ELEM_WIDTH-1:0]          rd_a_data,
   input  wire [2*ELEM_WIDTH-1:0]          rd_b_data,
   output logic                            done,
   output logic [cmm_pkg::IDX_W-1:0]       out_row,
   output logic [cmm_pkg::IDX_W-1:0]       out_col,
   output logic [cmm_pkg::OUT_W-1:0]       out_real,
   output logic [cmm_pkg::OUT_W-1:0]       out_imag,
   output logic                            out_last
);
   localparam int RW = $clog2(MAX_DIM) > 0 ? $clog2(MAX_DIM) : 1;
   localparam int PW = 2 * ELEM_WIDTH;
   localparam int W  = cmm_pkg::DIM_W;

   cmm_pkg::state_type state_ff, state_in;
   cmm_pkg::dims_type  dims_ff, dims_in;
   logic [W-1:0] r_ff, r_in, c_ff, c_in, k_ff, k_in;

   // pipeline control: read (s1), multiply (s2), accumulate (s3)
   typedef struct packed {
      logic valid;
      logic first;
      logic fin;
      logic lastel;
      logic [cmm_pkg::IDX_W-1:0] row;
      logic [cmm_pkg::IDX_W-1:0] col;
   } tag_type;
   tag_type t0, s1_ff, s2_ff;

   logic signed [PW-1:0] rr_ff, ii_ff, ri_ff, ir_ff;
   logic signed [cmm_pkg::OUT_W-1:0] acc_re_ff, acc_im_ff, acc_re_in, acc_im_in;
   logic s3_ff;
   logic issue, step_last;

   logic signed [ELEM_WIDTH-1:0] ar, ai, br, bi;
   assign ar = rd_a_data[PW-1:ELEM_WIDTH];
   assign ai = rd_a_data[ELEM_WIDTH-1:0];
   assign br = rd_b_data[PW-1:ELEM_WIDTH];
   assign bi = rd_b_data[ELEM_WIDTH-1:0];

   assign rd_a_addr = AW'({r_ff[RW-1:0], k_ff[RW-1:0]});
   assign rd_b_addr = AW'({k_ff[RW-1:0], c_ff[RW-1:0]});

   // sequencer
   always_comb begin
      state_in = state_ff;
      dims_in  = dims_ff;
      r_in = r_ff; c_in = c_ff; k_in = k_ff;
      cmd_take = 1'b0;
      issue = 1'b0;
      step_last = 1'b0;
      unique case (state_ff)
         cmm_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               dims_in  = cmd_dims;
               r_in = '0; c_in = '0; k_in = '0;
               state_in = cmm_pkg::ST_RUN;
            end
         end
         cmm_pkg::ST_RUN: begin
            issue = 1'b1;
            if (k_ff + W'(1) < dims_ff.inner) begin
               k_in = k_ff + W'(1);
            end else begin
               k_in = '0;
               if (c_ff + W'(1) < dims_ff.cols) begin
                  c_in = c_ff + W'(1);
               end else begin
                  c_in = '0;
                  if (r_ff + W'(1) < dims_ff.rows) begin
                     r_in = r_ff + W'(1);
                  end else begin
                     step_last = 1'b1;
                     state_in = cmm_pkg::ST_DRAIN;
                  end
               end
            end
         end
         cmm_pkg::ST_DRAIN: begin
            if (!s1_ff.valid && !s2_ff.valid && !s3_ff) state_in = cmm_pkg::ST_IDLE;
         end
         default: state_in = cmm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      t0.valid  = issue;
      t0.first  = (k_ff == '0);
      t0.fin    = (k_ff + W'(1) >= dims_ff.inner);
      t0.lastel = step_last;
      t0.row    = r_ff[cmm_pkg::IDX_W-1:0];
      t0.col    = c_ff[cmm_pkg::IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmm_pkg::ST_IDLE;
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         s1_ff.valid <= t0.valid;
         s2_ff.valid <= s1_ff.valid;
         s3_ff <= s2_ff.valid && s2_ff.fin;
      end
      dims_ff <= dims_in;
      r_ff <= r_in; c_ff <= c_in; k_ff <= k_in;
      {s1_ff.first, s1_ff.fin, s1_ff.lastel, s1_ff.row, s1_ff.col} <=
         {t0.first, t0.fin, t0.lastel, t0.row, t0.col};
      {s2_ff.first, s2_ff.fin, s2_ff.lastel, s2_ff.row, s2_ff.col} <=
         {s1_ff.first, s1_ff.fin, s1_ff.lastel, s1_ff.row, s1_ff.col};
      // four partial products, registered
      rr_ff <= ar * br;
      ii_ff <= ai * bi;
      ri_ff <= ar * bi;
      ir_ff <= ai * br;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      out_row  <= s2_ff.row;
      out_col  <= s2_ff.col;
      out_last <= s2_ff.lastel;
   end

   // accumulate
   always_comb begin
      logic signed [cmm_pkg::OUT_W-1:0] pre, pim;
      pre = cmm_pkg::OUT_W'(rr_ff) - cmm_pkg::OUT_W'(ii_ff);
      pim = cmm_pkg::OUT_W'(ri_ff) + cmm_pkg::OUT_W'(ir_ff);
      if (s2_ff.first) begin
         acc_re_in = pre;
         acc_im_in = pim;
      end else begin
         acc_re_in = acc_re_ff + pre;
         acc_im_in = acc_im_ff + pim;
      end
      if (!s2_ff.valid) begin
         acc_re_in = acc_re_ff;
         acc_im_in = acc_im_ff;
      end
   end

   assign done      = s3_ff;
   assign out_real  = acc_re_ff;
   assign out_imag  = acc_im_ff;
   assign back_busy = (state_ff != cmm_pkg::ST_IDLE);

   `ASSERT_NOW(a_done_not_idle, clock, reset, s3_ff, back_busy)
   `ASSERT_NEXT(a_last_ends, clock, reset, s3_ff && out_last, !s3_ff)
endmodule
`default_nettype wire

// ----- rtl/complex_matrix_multiply.sv -----
// ----------------------------------------------------------------------
// complex_matrix_multiply
// product of two complex matrices held in two element stores
// ----------------------------------------------------------------------
// usage:
//   an item is taken when start is high and busy is low. action 0 and 1
//   write one Q1.15 complex element of the first or second matrix, one per
//   cycle while busy is low. action 2 runs the product. a run emits
//   rows*cols beats on rsp_*, each marked by rsp_valid for one cycle, in
//   row-major order, rsp_last on the final one. the elements are computed
//   one after another on the shared multiply-accumulate; each result passes
//   the store read, the partial product registers and the accumulator
//   before its beat. busy stays high past the last beat until the pipeline
//   has drained, so the next item is taken only after it. the receiver
//   cannot stall the results. sizes are written on csr_* while idle; 0
//   reads as 1, above MAX_DIM as MAX_DIM. reset returns sizes to 8 and
//   clears control state; the stores keep undefined content until
//   written.
// ----------------------------------------------------------------------
`default_nettype none
module complex_matrix_multiply #(
   parameter int MAX_DIM = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire [1:0]                    req_action,
   input  wire [2:0]                    req_row_index,
   input  wire [2:0]                    req_col_index,
   input  wire signed [ELEM_WIDTH-1:0]  req_real_part,
   input  wire signed [ELEM_WIDTH-1:0]  req_imag_part,
   output logic                         rsp_valid,
   output logic [2:0]                   rsp_out_row,
   output logic [2:0]                   rsp_out_col,
   output logic signed [35:0]           rsp_out_real,
   output logic signed [35:0]           rsp_out_imag,
   output logic                         rsp_last,
   input  wire                          csr_we,
   input  wire [1:0]                    csr_index,
   input  wire [3:0]                    csr_wdata
);
   localparam int RW = $clog2(MAX_DIM) > 0 ? $clog2(MAX_DIM) : 1;
   localparam int AW = 2 * RW;
   localparam int DEPTH = 1 << AW;
   localparam int PW = 2 * ELEM_WIDTH;

   logic [3:0] rows_ff, inner_ff, cols_ff;

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 4'd8; inner_ff <= 4'd8; cols_ff <= 4'd8;
      end else if (csr_we) begin
         unique case (cmm_pkg::reg_index_type'(csr_index))
            cmm_pkg::REG_ROWS:  rows_ff  <= csr_wdata;
            cmm_pkg::REG_INNER: inner_ff <= csr_wdata;
            cmm_pkg::REG_COLS:  cols_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic wr_a, wr_b, cmd_valid, cmd_take, back_busy;
   logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;
   logic [PW-1:0] wr_data, rd_a_data, rd_b_data;
   cmm_pkg::dims_type cmd_dims;

   cmm_front #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH), .AW(AW)) u_front (
      .clock, .reset, .start, .busy, .req_action, .req_row_index, .req_col_index,
      .req_real_part, .req_imag_part, .cfg_rows(rows_ff), .cfg_inner(inner_ff),
      .cfg_cols(cols_ff), .wr_a, .wr_b, .wr_addr, .wr_data, .cmd_valid, .cmd_dims,
      .cmd_take, .back_busy
   );

   cmm_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_store_a (
      .clock, .wr_en(wr_a), .wr_addr, .wr_data, .rd_addr(rd_a_addr), .rd_data(rd_a_data)
   );
   cmm_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_store_b (
      .clock, .wr_en(wr_b), .wr_addr, .wr_data, .rd_addr(rd_b_addr), .rd_data(rd_b_data)
   );

   cmm_back #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH), .AW(AW)) u_back (
      .clock, .reset, .cmd_valid, .cmd_dims, .cmd_take, .back_busy,
      .rd_a_addr, .rd_b_addr, .rd_a_data, .rd_b_data, .done(rsp_valid),
      .out_row(rsp_out_row), .out_col(rsp_out_col), .out_real(rsp_out_real),
      .out_imag(rsp_out_imag), .out_last(rsp_last)
   );
endmodule
`default_nettype wire
